// ===== hdl/sacal_pkg.sv =====
package sacal_pkg;

    localparam int WAYS        = 4;
    localparam int INDEX_BITS  = 4;
    localparam int OFFSET_BITS = 2;
    localparam int ADDR_BITS   = 32;

    localparam int IN_ADDR_BITS = 32;
    localparam int WORD_BITS    = 32;
    localparam int CNT_BITS     = 32;
    localparam int AGE_BITS     = 2;

    localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_BITS  = ADDR_BITS - OFFSET_BITS - INDEX_BITS;
    localparam int LINE_BITS = INDEX_BITS + WAY_BITS;
    localparam int LINES     = 1 << LINE_BITS;

    localparam logic [AGE_BITS-1:0] AGE_MAX = AGE_BITS'(3);

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef logic [WAY_BITS-1:0]     t_way;
    typedef logic [INDEX_BITS-1:0]   t_set;
    typedef logic [TAG_BITS-1:0]     t_tag;
    typedef logic [AGE_BITS-1:0]     t_age;
    typedef logic [WORD_BITS-1:0]    t_word;
    typedef logic [LINE_BITS-1:0]    t_line;
    typedef logic [IN_ADDR_BITS-1:0] t_addr;
    typedef logic [CNT_BITS-1:0]     t_cnt;

    // one way of the set as read back from the line stores
    typedef struct packed {
        logic valid;
        t_tag tag;
        t_age age;
    } t_way_rd;

    // running state of the set sweep
    typedef struct packed {
        logic is_write;
        logic first;
        t_tag tag;
        logic found;
        t_age vic_age;
        logic vic_valid;
    } t_scan_ctx;

    // verdict on one way
    typedef struct packed {
        logic match;
        logic first_hit;
        logic age_we;
        t_age age_new;
        logic take_vic;
        t_age cand_age;
    } t_way_res;

endpackage

// ===== hdl/sacal_if.sv =====
interface sacal_req_if;
    import sacal_pkg::*;

    logic  valid;
    logic  ready;
    logic  func;
    t_addr addr;
    t_word wdata;
    t_word fill_word;

    modport source (output valid, func, addr, wdata, fill_word, input ready);
    modport sink   (input valid, func, addr, wdata, fill_word, output ready);
endinterface

interface sacal_rsp_if;
    import sacal_pkg::*;

    logic  valid;
    logic  ready;
    t_word rdata;
    logic  hit;
    t_cnt  hit_total;
    t_cnt  miss_total;

    modport source (output valid, rdata, hit, hit_total, miss_total, input ready);
    modport sink   (input valid, rdata, hit, hit_total, miss_total, output ready);
endinterface

// ===== hdl/sacal_way_eval.sv =====
module sacal_way_eval (
    input  sacal_pkg::t_way_rd   i_rd,
    input  sacal_pkg::t_scan_ctx i_ctx,
    output sacal_pkg::t_way_res  o_res
);
    import sacal_pkg::*;

    t_age aged;

    always_comb begin
        aged = (i_rd.valid && (i_rd.age != AGE_MAX)) ? i_rd.age + t_age'(1) : i_rd.age;

        o_res.match     = i_rd.valid && (i_rd.tag == i_ctx.tag);
        o_res.first_hit = o_res.match && !i_ctx.found;
        o_res.age_we    = !i_ctx.is_write && i_rd.valid;
        o_res.age_new   = o_res.first_hit ? '0 : aged;
        o_res.cand_age  = i_ctx.is_write ? i_rd.age : aged;
        // highest invalid way wins, else lowest way of largest age
        o_res.take_vic  = i_ctx.first || !i_rd.valid
                          || (i_ctx.vic_valid && (i_ctx.vic_age < o_res.cand_age));
    end

endmodule

// ===== hdl/set_assoc_cache_aging_lru.sv =====
// Four-way set-associative write-through cache, one word per line, with
// 2-bit saturating age counters for replacement.
// i_req (sink): one read or write request per handshake, carrying func,
//   addr, wdata and fill_word (the backing memory word, used on a read miss).
// o_rsp (source): one response per request: rdata (zero for writes), hit,
//   and the running read hit and read miss totals.
// A request is taken only while the block is idle. The set is then swept
// one way per cycle through the single read port of the tag, age and word
// stores, then a final step updates the chosen line and loads the response.
// Once the response is loaded, the block is idle and can take a new request.
// The response sits in an output register: a new request is accepted while
// it waits. If the receiver still stalls when the next response is done,
// the block holds in its final step until o_rsp.ready frees the register.
// Reset clears all line valid bits, both totals and the response valid;
// tags, words and ages are not cleared and are never read while invalid.
module set_assoc_cache_aging_lru (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sacal_req_if.sink   i_req,
    sacal_rsp_if.source o_rsp
);
    import sacal_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam t_way WAY_LAST = t_way'(WAYS - 1);

    t_tag  m_tag  [LINES];
    t_word m_word [LINES];
    t_age  m_age  [LINES];

    logic [1:0]       r_state, n_state;
    t_way             r_cnt;
    logic             r_func;
    t_set             r_set;
    t_tag             r_tag;
    t_word            r_wdata;
    t_word            r_fill;
    logic             r_found;
    t_way             r_hitw;
    t_word            r_word;
    t_way             r_vic;
    t_age             r_vic_age;
    logic             r_vic_v;
    logic [LINES-1:0] r_valid;
    t_tag             r_q_tag;
    t_age             r_q_age;
    t_word            r_q_word;
    logic             r_ov;
    t_word            r_o_rdata;
    logic             r_o_hit;
    t_cnt             r_hit_cnt;
    t_cnt             r_miss_cnt;

    logic      accept;
    logic      in_scan;
    logic      fin_go;
    t_line     rd_a;
    t_line     proc_line;
    t_line     fill_line;
    t_way_rd   rd;
    t_scan_ctx ctx;
    t_way_res  res;
    logic      tag_we;
    logic      word_we;
    t_word     word_wd;
    logic      age_we;
    t_line     age_wa;
    t_age      age_wd;

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign in_scan     = (r_state == ST_SCAN);
    assign fin_go      = (r_state == ST_FIN) && (!r_ov || o_rsp.ready);

    assign rd_a      = in_scan ? {r_set, r_cnt + t_way'(1)}
                               : {i_req.addr[OFFSET_BITS +: INDEX_BITS], t_way'(0)};
    assign proc_line = {r_set, r_cnt};
    assign fill_line = r_found ? {r_set, r_hitw} : {r_set, r_vic};

    always_comb begin
        rd.valid      = r_valid[proc_line];
        rd.tag        = r_q_tag;
        rd.age        = r_q_age;
        ctx.is_write  = (r_func == FUNC_WRITE);
        ctx.first     = (r_cnt == t_way'(0));
        ctx.tag       = r_tag;
        ctx.found     = r_found;
        ctx.vic_age   = r_vic_age;
        ctx.vic_valid = r_vic_v;
    end

    sacal_way_eval u_eval (
        .i_rd  (rd),
        .i_ctx (ctx),
        .o_res (res)
    );

    always_comb begin
        tag_we  = fin_go && !r_found;
        word_we = fin_go && (!r_found || (r_func == FUNC_WRITE));
        word_wd = (r_func == FUNC_WRITE) ? r_wdata : r_fill;
        age_we  = (in_scan && res.age_we) || word_we;
        age_wa  = in_scan ? proc_line : fill_line;
        age_wd  = in_scan ? res.age_new : '0;
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            m_tag[fill_line] <= r_tag;
        end
        if (word_we) begin
            m_word[fill_line] <= word_wd;
        end
        if (age_we) begin
            m_age[age_wa] <= age_wd;
        end
        r_q_tag  <= m_tag[rd_a];
        r_q_age  <= m_age[rd_a];
        r_q_word <= m_word[rd_a];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_cnt == WAY_LAST) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (fin_go) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= '0;
            r_ov       <= 1'b0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (fin_go) begin
                r_ov <= 1'b1;
                if (!r_found) begin
                    r_valid[fill_line] <= 1'b1;
                end
                if (r_func == FUNC_READ) begin
                    if (r_found) r_hit_cnt <= r_hit_cnt + t_cnt'(1);
                    else         r_miss_cnt <= r_miss_cnt + t_cnt'(1);
                end
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_req.func;
            r_set   <= i_req.addr[OFFSET_BITS +: INDEX_BITS];
            r_tag   <= i_req.addr[ADDR_BITS-1 : OFFSET_BITS+INDEX_BITS];
            r_wdata <= i_req.wdata;
            r_fill  <= i_req.fill_word;
            r_found <= 1'b0;
            r_cnt   <= '0;
        end else if (in_scan) begin
            r_cnt   <= r_cnt + t_way'(1);
            r_found <= r_found || res.match;
            if (res.first_hit) begin
                r_hitw <= r_cnt;
                r_word <= r_q_word;
            end
            if (res.take_vic) begin
                r_vic     <= r_cnt;
                r_vic_age <= res.cand_age;
                r_vic_v   <= rd.valid;
            end
        end
        if (fin_go) begin
            r_o_hit <= r_found;
            if (r_func == FUNC_WRITE) r_o_rdata <= '0;
            else if (r_found)         r_o_rdata <= r_word;
            else                      r_o_rdata <= r_fill;
        end
    end

    assign o_rsp.valid      = r_ov;
    assign o_rsp.rdata      = r_o_rdata;
    assign o_rsp.hit        = r_o_hit;
    assign o_rsp.hit_total  = r_hit_cnt;
    assign o_rsp.miss_total = r_miss_cnt;

`ifndef SYNTH
    a_rsp_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(r_state) == ST_FIN)
        else $error("response raised outside final step");

    a_hit_way_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_found) |-> r_valid[{r_set, r_hitw}])
        else $error("hit way is not valid");

    a_fill_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_go && !r_found) |=> r_valid[$past(fill_line)])
        else $error("filled line not marked valid");

    a_one_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hit_cnt != $past(r_hit_cnt)) |-> (r_miss_cnt == $past(r_miss_cnt)))
        else $error("hit and miss totals moved together");

    a_totals_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_FIN) |=> ($stable(r_hit_cnt) && $stable(r_miss_cnt)))
        else $error("totals changed outside final step");
`endif

endmodule

// ===== sim/set_assoc_cache_aging_lru_test.sv =====
`timescale 1ns / 1ps

module set_assoc_cache_aging_lru_test;
    import sacal_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 4 * (WAYS + 2);
    localparam int TAG_POOL    = 6;
    localparam int SET_COUNT   = 1 << INDEX_BITS;

    typedef struct packed {
        t_word rdata;
        logic  hit;
        t_cnt  hit_total;
        t_cnt  miss_total;
    } t_cache_rsp;

    logic i_clk;
    logic i_rst_n;

    sacal_req_if req_ch();
    sacal_rsp_if rsp_ch();

    set_assoc_cache_aging_lru dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // shadow copy of the cache
    t_tag  shadow_tag   [LINES];
    logic  shadow_valid [LINES];
    t_word shadow_word  [LINES];
    t_age  shadow_age   [LINES];
    t_cnt  shadow_hits;
    t_cnt  shadow_misses;

    t_cache_rsp rsp_queue[$];
    t_cache_rsp want_rsp;
    t_tag       tag_pool[TAG_POOL];

    int src_idle_pct;
    int snk_idle_pct;
    int fail_count;
    int cycle_count;
    int n_reads;
    int n_writes;
    int n_write_hits;
    int n_checked;

    function automatic t_addr line_addr(t_tag tag, t_set set_idx);
        return {tag, set_idx, OFFSET_BITS'(0)};
    endfunction

    // highest invalid way, else lowest way of largest age
    function automatic int pick_victim(int base);
        int v;
        v = 0;
        for (int w = 0; w < WAYS; w++) begin
            if (!shadow_valid[base + w] ||
                (shadow_valid[base + v] && shadow_age[base + v] < shadow_age[base + w])) begin
                v = w;
            end
        end
        return base + v;
    endfunction

    function automatic void place_line(int e, t_tag tag, t_word word);
        shadow_tag[e]   = tag;
        shadow_valid[e] = 1'b1;
        shadow_word[e]  = word;
        shadow_age[e]   = '0;
    endfunction

    function automatic t_cache_rsp predict_access(logic func, t_addr addr, t_word wdata,
                                                  t_word fill);
        t_set       set_idx;
        t_tag       tag;
        int         base;
        int         hit_e;
        logic       found;
        t_cache_rsp rsp;
        set_idx = addr[OFFSET_BITS +: INDEX_BITS];
        tag     = addr[OFFSET_BITS + INDEX_BITS +: TAG_BITS];
        base    = int'(set_idx) * WAYS;
        found   = 1'b0;
        hit_e   = base;
        for (int w = 0; w < WAYS; w++) begin
            if (!found && shadow_valid[base + w] && shadow_tag[base + w] == tag) begin
                found = 1'b1;
                hit_e = base + w;
            end
        end
        rsp.rdata = '0;
        rsp.hit   = found;
        if (func == FUNC_READ) begin
            n_reads++;
            for (int w = 0; w < WAYS; w++) begin
                if (found && base + w == hit_e) begin
                    shadow_age[base + w] = '0;
                end else if (shadow_valid[base + w] && shadow_age[base + w] < AGE_MAX) begin
                    shadow_age[base + w] = shadow_age[base + w] + 1'b1;
                end
            end
            if (found) begin
                rsp.rdata = shadow_word[hit_e];
                shadow_hits++;
            end else begin
                place_line(pick_victim(base), tag, fill);
                rsp.rdata = fill;
                shadow_misses++;
            end
        end else begin
            n_writes++;
            if (found) begin
                shadow_word[hit_e] = wdata;
                shadow_age[hit_e]  = '0;
                n_write_hits++;
            end else begin
                place_line(pick_victim(base), tag, wdata);
            end
        end
        rsp.hit_total  = shadow_hits;
        rsp.miss_total = shadow_misses;
        return rsp;
    endfunction

    task automatic send_request(logic func, t_addr addr, t_word wdata, t_word fill);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.func      <= func;
        req_ch.addr      <= addr;
        req_ch.wdata     <= wdata;
        req_ch.fill_word <= fill;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        rsp_queue.push_back(predict_access(func, addr, wdata, fill));
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (rsp_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // set 3: fill all ways, saturate ages, evict on an age tie
    task automatic test_fill_and_aging();
        t_set s;
        s = t_set'(3);
        for (int t = 1; t <= WAYS; t++) begin
            send_request(FUNC_READ, line_addr(t_tag'(t), s), 32'hDEAD_0000, 32'h1000_0000 + t);
        end
        send_request(FUNC_READ, line_addr(t_tag'(1), s), '0, 32'hBAD0_0001);
        send_request(FUNC_READ, line_addr(t_tag'(1), s) | 32'h3, '0, 32'hBAD0_0002);
        send_request(FUNC_WRITE, line_addr(t_tag'(2), s), 32'h2222_2222, 32'hBAD0_0003);
        send_request(FUNC_READ, line_addr(t_tag'(5), s), '0, 32'h5555_5555);
        send_request(FUNC_READ, line_addr(t_tag'(4), s), '0, 32'h4444_4444);
        send_request(FUNC_WRITE, line_addr(t_tag'(6), s), 32'h6666_6666, 32'hBAD0_0004);
        send_request(FUNC_READ, line_addr(t_tag'(6), s), '0, 32'hBAD0_0005);
    endtask

    task automatic test_address_extremes();
        send_request(FUNC_READ, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(FUNC_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(FUNC_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(FUNC_READ, 32'hFFFF_FFFC, 32'h0000_0000, 32'h1234_5678);
        send_request(FUNC_WRITE, 32'h0000_0003, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(FUNC_READ, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8765_4321);
    endtask

    // write miss allocates; repeated write to the same tag must not duplicate it
    task automatic test_write_allocate();
        t_addr a;
        a = line_addr(t_tag'(9), t_set'(7));
        send_request(FUNC_WRITE, a, 32'hCAFE_0001, 32'hBAD0_0010);
        send_request(FUNC_READ, a, '0, 32'hBAD0_0011);
        send_request(FUNC_WRITE, a, 32'hCAFE_0002, 32'hBAD0_0012);
        send_request(FUNC_READ, a, '0, 32'hBAD0_0013);
    endtask

    // mostly a small tag pool shared by all sets so hits and evictions are frequent
    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            t_addr a;
            logic  func;
            if ($urandom_range(99) < 85) begin
                a = {tag_pool[$urandom_range(TAG_POOL - 1)],
                     t_set'($urandom_range(SET_COUNT - 1)),
                     OFFSET_BITS'($urandom_range(3))};
            end else begin
                a = $urandom();
            end
            func = ($urandom_range(99) < 60) ? FUNC_READ : FUNC_WRITE;
            send_request(func, a, $urandom(), $urandom());
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("set_assoc_cache_aging_lru: mismatch");
        $finish;
    end

    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_queue.size() == 0) begin
                $display("%0t: response with no request pending", $time);
                fail_count++;
            end else begin
                want_rsp = rsp_queue.pop_front();
                n_checked++;
                check_field("rdata", want_rsp.rdata, rsp_ch.rdata);
                check_field("hit", 32'(want_rsp.hit), 32'(rsp_ch.hit));
                check_field("hit_total", want_rsp.hit_total, rsp_ch.hit_total);
                check_field("miss_total", want_rsp.miss_total, rsp_ch.miss_total);
            end
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.func      <= FUNC_READ;
        req_ch.addr      <= '0;
        req_ch.wdata     <= '0;
        req_ch.fill_word <= '0;
        fail_count    = 0;
        n_reads       = 0;
        n_writes      = 0;
        n_write_hits  = 0;
        n_checked     = 0;
        shadow_hits   = '0;
        shadow_misses = '0;
        for (int e = 0; e < LINES; e++) begin
            shadow_tag[e]   = '0;
            shadow_valid[e] = 1'b0;
            shadow_word[e]  = '0;
            shadow_age[e]   = '0;
        end
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int j = 2; j < TAG_POOL; j++) tag_pool[j] = t_tag'($urandom());
        src_idle_pct = 37;
        snk_idle_pct = 75;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_fill_and_aging();
        test_address_extremes();
        test_write_allocate();
        test_random(150);
        wait_drained();
        test_random(150);
        wait_drained();

        src_idle_pct = 75;
        snk_idle_pct = 37;
        test_random(300);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random(300);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("reads %0d (hits %0d, misses %0d), writes %0d (hits %0d)",
                 n_reads, shadow_hits, shadow_misses, n_writes, n_write_hits);
        $display("responses checked %0d, errors %0d", n_checked, fail_count);
        if (fail_count == 0) begin
            $display("set_assoc_cache_aging_lru: match");
        end else begin
            $display("set_assoc_cache_aging_lru: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/sacal_pkg.sv
hdl/sacal_if.sv
hdl/sacal_way_eval.sv
hdl/set_assoc_cache_aging_lru.sv
sim/set_assoc_cache_aging_lru_test.sv
